// ----- design/cps_pkg.sv -----
// Shared types and constants for the convex polygon separating-axis test.
// Used by the top level, the root/divide unit and the port checker.
package cps_pkg;

    localparam int XY_W        = 16;
    localparam int CAP_W       = 31;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;
    localparam int RAD_W       = 34;   // nx^2 + ny^2
    localparam int ROOT_W      = 17;
    localparam int DIV_W       = 18;   // 2 * length
    localparam int REM_W       = 21;
    localparam int STEP_W      = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 31'd16000;
    localparam logic [STEP_W-1:0] ROOT_STEPS = 5'd17;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 5'd16;
    localparam logic signed [XY_W-1:0] AXIS_ONE = 16'sd16384;

    typedef enum logic {
        OP_ROOT = 1'b0,
        OP_DIV  = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic              start;
        t_iter_op          op;
        logic [RAD_W-1:0]  value;    // radicand, or dividend in the low 32 bits
        logic [DIV_W-1:0]  divisor;
    } t_iter_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] result;
    } t_iter_rsp;

endpackage

// ----- design/convex_polygon_sat_collision_top.sv -----
// Vertex load: one beat per cycle; input is not ready from B's last vertex until the result.
// Test per axis: a square root, then two divides (none on a zero-length edge), on the
// shared root/divide unit, and the vertex projections on the single shared multiplier; the
// test stops at the first axis that separates. One result beat is registered.
// Reset (synchronous, active low) empties both polygons, clears the overflow flag and output
// valid, sets the overlap cap to 16000; vertex RAM is not cleared. Uses cps_pkg/ram/iter.
module convex_polygon_sat_collision_top
    import cps_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [CAP_W-1:0]       i_cfg_wdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // vertex_x, vertex_y
    input  logic                   i_s_tuser,   // which_shape
    input  logic                   i_s_tlast,   // last_vertex
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // colliding, overlap_depth, axis_x, axis_y, vertex_overflow
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int DEPTH = 2 * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);
    localparam logic [AW-1:0] B_BASE  = AW'(MAX_VERTICES);

    typedef enum logic [4:0] {
        S_LOAD, S_CHK, S_RD0, S_RD1, S_NRM, S_SQX, S_SQY, S_RTS, S_RTW,
        S_DXS, S_DXW, S_DYS, S_DYW, S_PRD, S_PX, S_PY, S_CMP, S_UPD, S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic                    r_load_b, n_load_b, r_ovf, n_ovf;
    logic [CAP_W-1:0]        r_cap;
    logic                    r_poly, n_poly, r_pp, n_pp, r_coll, n_coll;
    logic [CW-1:0]           r_e, n_e, r_idx, n_idx;
    logic [IN_TDATA_W-1:0]   r_v0, n_v0;
    logic signed [16:0]      r_nx, n_nx, r_ny, n_ny;
    logic [RAD_W-1:0]        r_acc, n_acc;
    logic [ROOT_W-1:0]       r_len, n_len;
    logic signed [XY_W-1:0]  r_ax, n_ax, r_ay, n_ay;
    logic signed [31:0]      r_amin, n_amin, r_amax, n_amax, r_bmin, n_bmin;
    logic signed [31:0]      r_bmax, n_bmax;
    logic [32:0]             r_o, n_o;
    logic [CAP_W-1:0]        r_best, n_best;
    logic signed [XY_W-1:0]  r_bx, n_bx, r_by, n_by;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [IN_TDATA_W-1:0]   ram_rdata;
    t_iter_req               iter_req;
    t_iter_rsp               iter_rsp;

    logic signed [16:0]      mul_a, mul_b;
    logic signed [33:0]      prod;
    logic                    in_acc;
    logic [CW-1:0]           cur_cnt, e_inc, nxt, pcnt;
    logic [AW-1:0]           base, pbase;
    logic signed [16:0]      rd_x, rd_y, v0_x, v0_y;
    logic signed [31:0]      proj;
    logic [16:0]             mag;
    logic                    neg;
    logic [31:0]             num;
    logic signed [32:0]      odiff;
    logic [33:0]             oround;
    logic [19:0]             oq;
    logic signed [XY_W-1:0]  qsig;

    cps_ram #(.WIDTH(IN_TDATA_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cps_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .o_rsp   (iter_rsp)
    );

    // one shared multiplier
    assign prod = mul_a * mul_b;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign cur_cnt = r_poly ? r_cnt_b : r_cnt_a;
    assign base    = r_poly ? B_BASE : '0;
    assign e_inc   = r_e + CW'(1);
    assign nxt     = (e_inc >= cur_cnt) ? '0 : e_inc;
    assign pcnt    = r_pp ? r_cnt_b : r_cnt_a;
    assign pbase   = r_pp ? B_BASE : '0;
    assign rd_x    = 17'(signed'(ram_rdata[15:0]));
    assign rd_y    = 17'(signed'(ram_rdata[31:16]));
    assign v0_x    = 17'(signed'(r_v0[15:0]));
    assign v0_y    = 17'(signed'(r_v0[31:16]));
    assign proj    = r_acc[31:0] + prod[31:0];
    assign oround  = {1'b0, r_o} + 34'd8192;
    assign oq      = oround[33:14];
    assign qsig    = neg ? -signed'(iter_rsp.result[15:0])
                         : signed'(iter_rsp.result[15:0]);

    always_comb begin
        mag = (r_state == S_DXS) ? 17'(r_nx < 0 ? -r_nx : r_nx)
                                 : 17'(r_ny < 0 ? -r_ny : r_ny);
        neg = (r_state == S_DXW) ? r_nx[16] : r_ny[16];
        num = {mag[15:0], 15'b0} + 32'(r_len);
        odiff = (r_amax <= r_bmax) ? 33'(r_amax) - 33'(r_bmin)
                                   : 33'(r_bmax) - 33'(r_amin);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_load_b    = r_load_b;
        n_ovf       = r_ovf;
        n_poly      = r_poly;
        n_pp        = r_pp;
        n_coll      = r_coll;
        n_e         = r_e;
        n_idx       = r_idx;
        n_v0        = r_v0;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_acc       = r_acc;
        n_len       = r_len;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_amin      = r_amin;
        n_amax      = r_amax;
        n_bmin      = r_bmin;
        n_bmax      = r_bmax;
        n_o         = r_o;
        n_best      = r_best;
        n_bx        = r_bx;
        n_by        = r_by;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        o_s_tready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        mul_a       = r_nx;
        mul_b       = r_nx;
        iter_req    = '{start: 1'b0, op: OP_ROOT, value: r_acc, divisor: '0};

        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                if (in_acc) begin
                    if (!i_s_tuser) begin
                        // A vertices after A closed are ignored
                        if (!r_load_b) begin
                            if (r_cnt_a < CNT_MAX) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_cnt_a);
                                n_cnt_a   = r_cnt_a + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_s_tlast) n_load_b = 1'b1;
                        end
                    end else begin
                        if (r_cnt_b < CNT_MAX) begin
                            ram_we    = 1'b1;
                            ram_waddr = B_BASE + AW'(r_cnt_b);
                            n_cnt_b   = r_cnt_b + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_s_tlast) n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_bx   = '0;
                n_by   = '0;
                n_poly = 1'b0;
                n_e    = '0;
                if (r_cnt_a == '0 || r_cnt_b == '0) begin
                    n_coll  = 1'b0;
                    n_best  = '0;
                    n_state = S_DONE;
                end else begin
                    n_coll  = 1'b1;
                    n_best  = r_cap;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                ram_re    = 1'b1;
                ram_raddr = base + AW'(r_e);
                n_state   = S_RD1;
            end
            S_RD1: begin
                n_v0      = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = base + AW'(nxt);
                n_state   = S_NRM;
            end
            S_NRM: begin
                n_nx    = rd_y - v0_y;
                n_ny    = v0_x - rd_x;
                n_state = S_SQX;
            end
            S_SQX: begin
                n_acc   = RAD_W'(unsigned'(prod));
                n_state = S_SQY;
            end
            S_SQY: begin
                mul_a   = r_ny;
                mul_b   = r_ny;
                n_acc   = r_acc + RAD_W'(unsigned'(prod));
                n_state = S_RTS;
            end
            S_RTS: begin
                iter_req.start = 1'b1;
                n_state        = S_RTW;
            end
            S_RTW: begin
                if (iter_rsp.done) begin
                    n_len = iter_rsp.result;
                    if (iter_rsp.result == '0) begin
                        // zero-length edge keeps a zero axis
                        n_ax    = '0;
                        n_ay    = '0;
                        n_pp    = 1'b0;
                        n_idx   = '0;
                        n_state = S_PRD;
                    end else begin
                        n_state = S_DXS;
                    end
                end
            end
            S_DXS, S_DYS: begin
                iter_req.start   = 1'b1;
                iter_req.op      = OP_DIV;
                iter_req.value   = RAD_W'(num);
                iter_req.divisor = {r_len, 1'b0};
                n_state          = (r_state == S_DXS) ? S_DXW : S_DYW;
            end
            S_DXW: begin
                if (iter_rsp.done) begin
                    n_ax    = qsig;
                    n_state = S_DYS;
                end
            end
            S_DYW: begin
                if (iter_rsp.done) begin
                    n_ay    = qsig;
                    n_pp    = 1'b0;
                    n_idx   = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                ram_re    = 1'b1;
                ram_raddr = pbase + AW'(r_idx);
                n_state   = S_PX;
            end
            S_PX: begin
                mul_a   = 17'(r_ax);
                mul_b   = rd_x;
                n_acc   = RAD_W'(unsigned'(prod));
                n_state = S_PY;
            end
            S_PY: begin
                mul_a = 17'(r_ay);
                mul_b = rd_y;
                if (!r_pp) begin
                    if (r_idx == '0 || proj < r_amin) n_amin = proj;
                    if (r_idx == '0 || proj > r_amax) n_amax = proj;
                end else begin
                    if (r_idx == '0 || proj < r_bmin) n_bmin = proj;
                    if (r_idx == '0 || proj > r_bmax) n_bmax = proj;
                end
                n_idx   = r_idx + CW'(1);
                n_state = S_PRD;
                if (r_idx + CW'(1) >= pcnt) begin
                    n_idx = '0;
                    if (!r_pp) n_pp = 1'b1;
                    else       n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!(r_amax >= r_bmin && r_bmax >= r_amin)) begin
                    n_coll  = 1'b0;
                    n_best  = '0;
                    n_bx    = '0;
                    n_by    = '0;
                    n_state = S_DONE;
                end else begin
                    n_o     = odiff < 0 ? 33'(-odiff) : 33'(odiff);
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (CAP_W'(oq) < r_best) begin
                    n_best = CAP_W'(oq);
                    n_bx   = r_ax;
                    n_by   = r_ay;
                end
                n_state = S_RD0;
                if (e_inc >= cur_cnt) begin
                    n_e = '0;
                    if (!r_poly) n_poly = 1'b1;
                    else         n_state = S_DONE;
                end else begin
                    n_e = e_inc;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'b0, r_ovf, r_by, r_bx, r_best, r_coll};
                    n_cnt_a     = '0;
                    n_cnt_b     = '0;
                    n_load_b    = 1'b0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_load_b    <= 1'b0;
            r_ovf       <= 1'b0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_load_b    <= n_load_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_wen) r_cap <= i_cfg_wdata;
        end
        r_poly     <= n_poly;
        r_pp       <= n_pp;
        r_coll     <= n_coll;
        r_e        <= n_e;
        r_idx      <= n_idx;
        r_v0       <= n_v0;
        r_nx       <= n_nx;
        r_ny       <= n_ny;
        r_acc      <= n_acc;
        r_len      <= n_len;
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_amin     <= n_amin;
        r_amax     <= n_amax;
        r_bmin     <= n_bmin;
        r_bmax     <= n_bmax;
        r_o        <= n_o;
        r_best     <= n_best;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- design/cps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cps_iter.sv -----
// Shared iterative unit: integer square root two bits a cycle per root digit,
// restoring division one quotient bit a cycle. Uses cps_pkg.
module cps_iter
    import cps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iter_req i_req,
    output t_iter_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    t_iter_op          r_op, n_op;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [RAD_W-1:0]  r_src, n_src;
    logic [DIV_W-1:0]  r_div, n_div;

    logic [REM_W-1:0]  sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb begin
        if (r_op == OP_ROOT) begin
            sh    = {r_rem[REM_W-3:0], r_src[RAD_W-1 -: 2]};
            trial = {2'b00, r_root, 2'b01};
        end else begin
            sh    = {r_rem[REM_W-2:0], r_src[RAD_W-1]};
            trial = {{(REM_W-DIV_W){1'b0}}, r_div};
        end
        diff = {1'b0, sh} - {1'b0, trial};
        ge   = !diff[REM_W];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_root = r_root;
        n_src  = r_src;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_root = '0;
            n_div  = i_req.divisor;
            if (i_req.op == OP_ROOT) begin
                n_cnt = ROOT_STEPS - 5'd1;
                n_rem = '0;
                n_src = i_req.value;
            end else begin
                // high half is already below the divisor
                n_cnt = DIV_STEPS - 5'd1;
                n_rem = REM_W'(i_req.value[31:16]);
                n_src = {i_req.value[15:0], {(RAD_W-16){1'b0}}};
            end
        end else if (r_busy) begin
            n_rem  = ge ? diff[REM_W-1:0] : sh;
            n_root = {r_root[ROOT_W-2:0], ge};
            n_src  = (r_op == OP_ROOT) ? {r_src[RAD_W-3:0], 2'b00}
                                       : {r_src[RAD_W-2:0], 1'b0};
            n_cnt  = r_cnt - 5'd1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_ROOT;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_src  <= n_src;
        r_div  <= n_div;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_root;

endmodule

// ----- design/cps_checker.sv -----
// Port-level checks on the result channel of the collision block, bound to
// the top level. Uses cps_pkg.
module cps_checker
    import cps_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // separated or empty: depth and axis are zero
    a_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[63:1] == '0)
        else $error("non-colliding result carries depth or axis");

    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $signed(o_m_tdata[47:32]) <= AXIS_ONE
                    && $signed(o_m_tdata[47:32]) >= -AXIS_ONE
                    && $signed(o_m_tdata[63:48]) <= AXIS_ONE
                    && $signed(o_m_tdata[63:48]) >= -AXIS_ONE)
        else $error("axis component beyond unit length");

endmodule

bind convex_polygon_sat_collision_top cps_checker u_cps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- tb/sv/cps_checker.sv -----
// Beat monitor and predictor for the convex polygon separating-axis test.
// Watches the vertex, result and cap-write channels; depends on cps_pkg.
`timescale 1ns / 100ps
module cps_tb_monitor
    import cps_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [CAP_W-1:0]       i_cfg_wdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct {
        bit                   colliding;
        bit [CAP_W-1:0]       depth;
        bit [XY_W-1:0]        axis_x;
        bit [XY_W-1:0]        axis_y;
        bit                   overflow;
    } t_sat_result;

    logic signed [XY_W-1:0] px [2*MAX_VERTICES];
    logic signed [XY_W-1:0] py [2*MAX_VERTICES];
    int                     num_a;
    int                     num_b;
    bit                     b_phase;
    bit                     dropped;
    logic [CAP_W-1:0]       cap;
    t_sat_result            sat_queue [$];

    assign o_pending = sat_queue.size();

    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // round to nearest, halves away from zero
    function automatic longint unit_part(longint n, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = longint'(n < 0 ? -n : n) * 64'd16384;
        q = (mag * 2 + len) / (2 * len);
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic span(input int base, input int cnt, input longint ax, input longint ay,
                        output longint mn, output longint mx);
        longint p;
        p = ax * longint'(px[base]) + ay * longint'(py[base]);
        mn = p;
        mx = p;
        for (int i = 1; i < cnt; i++) begin
            p = ax * longint'(px[base + i]) + ay * longint'(py[base + i]);
            if (p < mn) mn = p;
            else if (p > mx) mx = p;
        end
    endtask

    task automatic predict_sat(output t_sat_result res);
        longint best;
        longint bx, by, nx, ny, ax, ay, amin, amax, bmin, bmax, o, oq;
        longint unsigned len;
        int base, cnt, nxt;
        res = '{default: 0};
        res.overflow = dropped;
        best = longint'(cap);
        bx = 0;
        by = 0;
        if (num_a == 0 || num_b == 0) return;
        for (int poly = 0; poly < 2; poly++) begin
            base = poly ? MAX_VERTICES : 0;
            cnt = poly ? num_b : num_a;
            for (int e = 0; e < cnt; e++) begin
                nxt = (e + 1 >= cnt) ? 0 : e + 1;
                nx = longint'(py[base + nxt]) - longint'(py[base + e]);
                ny = longint'(px[base + e]) - longint'(px[base + nxt]);
                len = floor_root(longint'(nx * nx + ny * ny));
                ax = 0;
                ay = 0;
                if (len != 0) begin
                    ax = unit_part(nx, len);
                    ay = unit_part(ny, len);
                end
                span(0, num_a, ax, ay, amin, amax);
                span(MAX_VERTICES, num_b, ax, ay, bmin, bmax);
                // separated on this axis: no collision
                if (!(amax >= bmin && bmax >= amin)) return;
                o = (amax <= bmax) ? amax - bmin : bmax - amin;
                if (o < 0) o = -o;
                oq = (o + 8192) >>> 14;
                if (oq < best) begin
                    best = oq;
                    bx = ax;
                    by = ay;
                end
            end
        end
        res.colliding = 1;
        res.depth = best[CAP_W-1:0];
        res.axis_x = bx[XY_W-1:0];
        res.axis_y = by[XY_W-1:0];
    endtask

    task automatic take_vertex(input bit to_b, input logic [IN_TDATA_W-1:0] d, input bit last);
        t_sat_result res;
        if (!to_b) begin
            if (b_phase) return;
            if (num_a < MAX_VERTICES) begin
                px[num_a] = d[15:0];
                py[num_a] = d[31:16];
                num_a++;
            end else begin
                dropped = 1;
            end
            if (last) b_phase = 1;
            return;
        end
        if (num_b < MAX_VERTICES) begin
            px[MAX_VERTICES + num_b] = d[15:0];
            py[MAX_VERTICES + num_b] = d[31:16];
            num_b++;
        end else begin
            dropped = 1;
        end
        if (!last) return;
        predict_sat(res);
        sat_queue = {sat_queue, res};
        num_a = 0;
        num_b = 0;
        b_phase = 0;
        dropped = 0;
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
        t_sat_result want;
        if (sat_queue.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, d);
            o_errors++;
            return;
        end
        want = sat_queue.pop_front();
        if (d[0] !== want.colliding) begin
            $display("%0t: colliding expected %0d actual %0d", $time, want.colliding, d[0]);
            o_errors++;
        end
        if (d[31:1] !== want.depth) begin
            $display("%0t: overlap_depth expected %0d actual %0d", $time, want.depth, d[31:1]);
            o_errors++;
        end
        if (d[47:32] !== want.axis_x) begin
            $display("%0t: axis_x expected %h actual %h", $time, want.axis_x, d[47:32]);
            o_errors++;
        end
        if (d[63:48] !== want.axis_y) begin
            $display("%0t: axis_y expected %h actual %h", $time, want.axis_y, d[63:48]);
            o_errors++;
        end
        if (d[64] !== want.overflow) begin
            $display("%0t: vertex_overflow expected %0d actual %0d", $time, want.overflow, d[64]);
            o_errors++;
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            num_a = 0;
            num_b = 0;
            b_phase = 0;
            dropped = 0;
            cap = CAP_RESET;
        end else begin
            if (i_cfg_wen) cap = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) take_vertex(i_s_tuser, i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata);
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Stimulus and verdict for the convex polygon separating-axis test.
// Depends on cps_pkg, the block and cps_tb_monitor.
`timescale 1ns / 100ps
module testbench;
    import cps_pkg::*;

    localparam int  NUM_ITEMS = 1150;
    localparam int  LIMIT     = 3000000;
    localparam real TWO_PI    = 6.283185307179586;

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_cfg_wen = 0;
    logic [CAP_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tuser = 0;
    logic                   i_s_tlast = 0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    int errors;
    int pending;
    int cycles = 0;
    int items_sent = 0;
    bit steady = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always #5 i_clk = ~i_clk;

    convex_polygon_sat_collision_top #(.MAX_VERTICES(16)) uut (.*);

    cps_tb_monitor #(.MAX_VERTICES(16)) u_monitor (
        .i_clk, .i_rst_n, .i_cfg_wen, .i_cfg_wdata,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser, .i_s_tlast,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 12000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= steady || ($urandom_range(99) >= 31);
        end
    end

    function automatic logic signed [XY_W-1:0] clip(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[XY_W-1:0];
    endfunction

    task automatic send_vertex(input bit shape, input int x, input int y, input bit last);
        logic signed [XY_W-1:0] cx, cy;
        cx = clip(x);
        cy = clip(y);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 31) begin
            i_s_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {cy, cx};
        i_s_tuser <= shape;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // vertices around a circle, in order, so the polygon is convex
    task automatic send_poly(input bit shape, input int cx, input int cy, input int r,
                             input int n, input bit mark_last);
        real phase, ang;
        phase = $urandom_range(999) * TWO_PI / 1000.0;
        for (int k = 0; k < n; k++) begin
            ang = phase + TWO_PI * k / n;
            send_vertex(shape, cx + $rtoi(r * $cos(ang)), cy + $rtoi(r * $sin(ang)),
                        mark_last && (k == n - 1));
        end
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_s_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] v);
        drain();
        i_cfg_wen <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_wen <= 0;
    endtask

    function automatic int pick_count;
        int u;
        u = $urandom_range(99);
        if (u < 4) return 16;
        if (u < 8) return $urandom_range(20, 17);
        return $urandom_range(8, 3);
    endfunction

    task automatic random_pair;
        int kind, cx, cy, r1, r2, sc, na, nb;
        kind = $urandom_range(99);
        sc = ($urandom_range(3) == 0) ? 12000 : 400;
        cx = $urandom_range(2 * sc) - sc;
        cy = $urandom_range(2 * sc) - sc;
        r1 = $urandom_range(sc, 8);
        r2 = $urandom_range(sc, 8);
        na = pick_count();
        nb = pick_count();
        if (kind < 70) begin
            send_poly(0, cx, cy, r1, na, 1);
            send_poly(1, cx + $urandom_range(2 * sc) - sc, cy + $urandom_range(2 * sc) - sc,
                      r2, nb, 1);
        end else if (kind < 78) begin
            // A never closed: B still tests what A holds
            send_poly(0, cx, cy, r1, $urandom_range(4, 0), 0);
            send_poly(1, cx, cy + $urandom_range(sc), r2, nb, 1);
        end else if (kind < 86) begin
            // A vertices after A closed are dropped
            send_poly(0, cx, cy, r1, na, 1);
            send_vertex(0, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                        1'($urandom_range(1)));
            send_poly(1, cx - r1, cy, r2, nb, 1);
        end else begin
            // noise: arbitrary coordinates and mixed shapes
            repeat ($urandom_range(6, 1))
                send_vertex(1'($urandom_range(1)), $urandom_range(65535) - 32768,
                            $urandom_range(65535) - 32768, $urandom_range(3) == 0);
            send_vertex(1, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768, 1);
        end
    endtask

    initial begin
        int phase;
        int tests;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;

        // empty A
        send_vertex(1, 0, 0, 1);
        // coordinate extremes, identical triangles
        send_vertex(0, -32768, -32768, 0);
        send_vertex(0, 32767, -32768, 0);
        send_vertex(0, 0, 32767, 1);
        send_vertex(1, -32768, -32768, 0);
        send_vertex(1, 32767, -32768, 0);
        send_vertex(1, 0, 32767, 1);
        // zero-length edge in A
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 160, 0, 0);
        send_vertex(0, 0, 160, 1);
        send_vertex(1, 32, 32, 0);
        send_vertex(1, 48, 32, 0);
        send_vertex(1, 32, 48, 1);
        // stray A after close, then a far-away B
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 100, 0, 1);
        send_vertex(0, 5000, 5000, 1);
        send_vertex(1, 20000, 20000, 0);
        send_vertex(1, 20100, 20000, 1);
        // B arrives before A closed
        send_vertex(0, 0, 0, 0);
        send_vertex(0, 100, 0, 0);
        send_vertex(1, 50, -10, 0);
        send_vertex(1, 150, 0, 0);
        send_vertex(1, 50, 100, 1);

        tests = 0;
        phase = 0;
        while (items_sent < NUM_ITEMS) begin
            if (items_sent / 190 != phase) begin
                phase = items_sent / 190;
                unique case (phase)
                    1: write_cap('0);
                    2: write_cap('1);
                    3: write_cap(CAP_W'($urandom_range(2000, 1)));
                    4: write_cap(CAP_W'($urandom_range(32'h7FFF_FFFF)));
                    default: write_cap(CAP_RESET);
                endcase
            end
            steady = (tests >= 20 && tests < 35);
            if (tests == 50) hold_asks++;
            random_pair();
            tests++;
        end

        drain();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- convex_polygon_sat_collision_top.f -----
design/cps_pkg.sv
design/cps_ram.sv
design/cps_iter.sv
design/convex_polygon_sat_collision_top.sv
design/cps_checker.sv
tb/sv/cps_checker.sv
tb/sv/testbench.sv
